// ----- sv/wsbs_pkg.sv -----
`timescale 1ns / 1ps

package wsbs_pkg;

    localparam int SIG_BYTES = 16;
    localparam int CFG_WIDTH = 64;
    localparam int CFG_INDEX_BITS = 3;
    localparam int LEN_BITS = 5;
    localparam int SIG_INDEX_BITS = 4;

    localparam logic [CFG_INDEX_BITS-1:0] REG_BASE_ADDRESS = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LOW  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_HIGH = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_CARE_MASK    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PATTERN_LEN  = 3'd4;

    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef struct packed {
        logic       active;
        logic       care;
        logic [7:0] value;
    } cell_pat_t;

endpackage

// ----- sv/wsbs_cell.sv -----
`timescale 1ns / 1ps

module wsbs_cell
    import wsbs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  cell_pat_t  pat,
    input  logic [7:0] shift_in,
    output logic [7:0] byte_q,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic [7:0] byte_shift;

    assign byte_shift = ctrl.shift ? shift_in : byte_reg;
    assign byte_next  = ctrl.clear ? 8'd0 : byte_shift;
    assign byte_q     = byte_reg;
    assign hit        = !pat.active || !pat.care || (byte_shift == pat.value);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

endmodule

// ----- sv/wildcard_byte_signature_scan.sv -----
`timescale 1ns / 1ps

// Wildcard byte signature scan.
// Input channel (s_): one byte of a memory region per item, s_tlast on the
// final byte of the region. Each last byte starts a new region.
// Result channel (m_): at most one item per region. m_tuser is 1 when the
// signature matched and m_tdata then holds base address plus the offset of
// the match start; m_tuser 0 with m_tdata 0 means the region ended without
// a match. Bytes after a match give no result.
// Configuration: write cfg_data to register cfg_index while cfg_wr_en is high,
// only while the scanner is idle.
// Throughput: one byte per cycle while s_tready is high, set by the row of window
// cells that shift and compare in the cycle a byte is accepted.
// Pipeline: a result is registered in the p1 stage and then in the m_ output stage.
// Reset clears the window, fill, offset and the valid flags of the result stages;
// registers return to care mask all ones, length one, all others zero.
// When the receiver stalls, one result waits on m_ and one more in the stage
// behind it; s_tready drops only when both are held.
module wildcard_byte_signature_scan
    import wsbs_pkg::*;
#(
    parameter int PATTERN_BYTES = 16,
    parameter int OFFSET_BITS   = 32
)(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]      cfg_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // data_byte
    input  logic                      s_tlast,   // last_byte
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [63:0]               m_tdata,   // match_address
    output logic                      m_tuser    // found
);

    localparam int FILL_BITS = $clog2(PATTERN_BYTES + 1);
    localparam logic [FILL_BITS-1:0] FILL_MAX = FILL_BITS'(PATTERN_BYTES);
    localparam logic [LEN_BITS-1:0]  LEN_MAX  = LEN_BITS'(PATTERN_BYTES);

    logic [63:0]          base_reg;
    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_high_reg;
    logic [15:0]          care_reg;
    logic [LEN_BITS-1:0]  length_reg;

    logic [FILL_BITS-1:0]   fill_reg, fill_next, fill_shift;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next, offset_inc;
    logic                   matched_reg, matched_next;

    logic                   p1_valid_reg, p1_found_reg;
    logic [OFFSET_BITS-1:0] p1_start_reg;

    logic [7:0]          sig_bytes [SIG_BYTES];
    logic [LEN_BITS-1:0] len;
    logic [LEN_BITS-1:0] len_m1;
    logic                accept;
    logic                out_load;
    logic                match;
    logic                res_valid;
    cell_ctrl_t          ctrl;
    logic [PATTERN_BYTES-1:0] hits;
    logic [7:0]          cell_q [PATTERN_BYTES];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            sig_bytes[i]     = pat_low_reg[8*i +: 8];
            sig_bytes[i + 8] = pat_high_reg[8*i +: 8];
        end
    end

    always_comb begin
        if (length_reg == '0) begin
            len = LEN_BITS'(1);
        end else if (length_reg > LEN_MAX) begin
            len = LEN_MAX;
        end else begin
            len = length_reg;
        end
    end
    assign len_m1 = len - LEN_BITS'(1);

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg     <= '0;
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            care_reg     <= 16'hFFFF;
            length_reg   <= LEN_BITS'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_BASE_ADDRESS: begin
                    base_reg <= cfg_data[63:0];
                end
                REG_PATTERN_LOW: begin
                    pat_low_reg <= cfg_data[63:0];
                end
                REG_PATTERN_HIGH: begin
                    pat_high_reg <= cfg_data[63:0];
                end
                REG_CARE_MASK: begin
                    care_reg <= cfg_data[15:0];
                end
                REG_PATTERN_LEN: begin
                    length_reg <= cfg_data[LEN_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_load = !m_tvalid || m_tready;
    assign s_tready = !p1_valid_reg || out_load;
    assign accept   = s_tvalid && s_tready;

    assign ctrl.shift = accept && !matched_reg;
    assign ctrl.clear = accept && s_tlast;

    // window cells, cell k holds the byte k items back
    for (genvar k = 0; k < PATTERN_BYTES; k++) begin : g_cell
        localparam logic [LEN_BITS-1:0] KPOS = LEN_BITS'(k);
        cell_pat_t                 pat;
        logic [LEN_BITS-1:0]       sig_pos;
        logic [7:0]                shift_in;

        assign sig_pos    = len_m1 - KPOS;
        assign pat.active = KPOS < len;
        assign pat.care   = care_reg[sig_pos[SIG_INDEX_BITS-1:0]];
        assign pat.value  = sig_bytes[sig_pos[SIG_INDEX_BITS-1:0]];

        if (k == 0) begin : g_head
            assign shift_in = s_tdata;
        end else begin : g_link
            assign shift_in = cell_q[k-1];
        end

        wsbs_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctrl     (ctrl),
            .pat      (pat),
            .shift_in (shift_in),
            .byte_q   (cell_q[k]),
            .hit      (hits[k])
        );
    end

    assign fill_shift = (fill_reg < FILL_MAX) ? fill_reg + FILL_BITS'(1) : fill_reg;
    assign offset_inc = (offset_reg == '1) ? offset_reg : offset_reg + OFFSET_BITS'(1);

    assign match     = ctrl.shift && (LEN_BITS'(fill_shift) >= len) && (&hits);
    assign res_valid = ctrl.shift && (match || s_tlast);

    always_comb begin
        fill_next    = fill_reg;
        offset_next  = offset_reg;
        matched_next = matched_reg;
        if (accept) begin
            if (s_tlast) begin
                fill_next    = '0;
                offset_next  = '0;
                matched_next = 1'b0;
            end else begin
                offset_next  = offset_inc;
                matched_next = matched_reg || match;
                if (ctrl.shift) begin
                    fill_next = fill_shift;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg    <= '0;
            offset_reg  <= '0;
            matched_reg <= 1'b0;
        end else begin
            fill_reg    <= fill_next;
            offset_reg  <= offset_next;
            matched_reg <= matched_next;
        end
    end

    // result stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_tvalid     <= 1'b0;
        end else begin
            if (s_tready) begin
                p1_valid_reg <= accept && res_valid;
            end
            if (out_load) begin
                m_tvalid <= p1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready) begin
            p1_found_reg <= match;
            p1_start_reg <= match ? offset_reg - OFFSET_BITS'(len_m1) : '0;
        end
        if (out_load) begin
            m_tuser <= p1_found_reg;
            m_tdata <= p1_found_reg ? base_reg + 64'(p1_start_reg) : 64'd0;
        end
    end

endmodule

// ----- dv/wsbs_scan_checker.sv -----
`timescale 1ns / 1ps

module wsbs_scan_checker
    import wsbs_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]      cfg_data,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic [7:0]                s_tdata,   // data_byte
    input  logic                      s_tlast,   // last_byte
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [63:0]               m_tdata,   // match_address
    input  logic                      m_tuser,   // found
    output int                        fail_count,
    output int                        pending_results,
    output int                        results_checked,
    output int                        hits_seen
);

    localparam int OFFSET_BITS = 32;
    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    typedef struct packed {
        logic        found;
        logic [63:0] address;
    } scan_result_t;

    scan_result_t scan_results_due[$];

    logic [63:0]          base_addr;
    logic [63:0]          sig_low;
    logic [63:0]          sig_high;
    logic [15:0]          care_bits;
    logic [LEN_BITS-1:0]  sig_len;

    logic [7:0]           window [SIG_BYTES];
    int unsigned          window_fill;
    logic [OFFSET_BITS-1:0] region_offset;
    logic                 matched;

    function automatic int unsigned used_length();
        int unsigned n;
        n = sig_len;
        if (n < 1)
            n = 1;
        if (n > SIG_BYTES)
            n = SIG_BYTES;
        return n;
    endfunction

    function automatic logic [7:0] sig_at(int unsigned j);
        if (j < 8)
            return sig_low[8*j +: 8];
        return sig_high[8*(j-8) +: 8];
    endfunction

    function automatic logic window_hit(int unsigned n);
        if (window_fill < n)
            return 1'b0;
        for (int unsigned j = 0; j < n; j++) begin
            if (care_bits[j] && window[n-1-j] != sig_at(j))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void clear_region();
        for (int k = 0; k < SIG_BYTES; k++)
            window[k] = 8'h00;
        window_fill = 0;
        region_offset = '0;
        matched = 1'b0;
    endfunction

    function automatic void scan_byte(logic [7:0] b, logic is_last);
        logic [OFFSET_BITS-1:0] at;
        int unsigned n;
        scan_result_t r;
        at = region_offset;
        n = used_length();
        if (region_offset != OFFSET_MAX)
            region_offset++;
        if (!matched) begin
            for (int k = SIG_BYTES - 1; k > 0; k--)
                window[k] = window[k-1];
            window[0] = b;
            if (window_fill < SIG_BYTES)
                window_fill++;
            if (window_hit(n)) begin
                r.found = 1'b1;
                r.address = base_addr + 64'(at - OFFSET_BITS'(n - 1));
                matched = 1'b1;
                scan_results_due.push_back(r);
            end else if (is_last) begin
                r.found = 1'b0;
                r.address = '0;
                scan_results_due.push_back(r);
            end
        end
        if (is_last)
            clear_region();
    endfunction

    always @(posedge aclk) begin
        scan_result_t want;
        if (!aresetn) begin
            base_addr = '0;
            sig_low = '0;
            sig_high = '0;
            care_bits = 16'hFFFF;
            sig_len = LEN_BITS'(1);
            clear_region();
            scan_results_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (m_tuser === 1'b1)
                    hits_seen++;
                if (scan_results_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result: found=%b address=%h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = scan_results_due.pop_front();
                    if (m_tuser !== want.found || m_tdata !== want.address)
                        fail_count++;
                    if (m_tuser !== want.found)
                        $display("%0t: found mismatch: expected %b, actual %b",
                                 $time, want.found, m_tuser);
                    if (m_tdata !== want.address)
                        $display("%0t: address mismatch: expected %h, actual %h",
                                 $time, want.address, m_tdata);
                end
            end
            if (s_tvalid && s_tready)
                scan_byte(s_tdata, s_tlast);
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_ADDRESS: base_addr = cfg_data;
                    REG_PATTERN_LOW:  sig_low = cfg_data;
                    REG_PATTERN_HIGH: sig_high = cfg_data;
                    REG_CARE_MASK:    care_bits = cfg_data[15:0];
                    REG_PATTERN_LEN:  sig_len = cfg_data[LEN_BITS-1:0];
                    default: ;
                endcase
            end
        end
        pending_results = scan_results_due.size();
    end

endmodule

// ----- dv/wildcard_byte_signature_scan_tb.sv -----
`timescale 1ns / 1ps

module wildcard_byte_signature_scan_tb;
    import wsbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS = 250;
    localparam int SETTINGS_RUN = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_FIRST = REG_PATTERN_LEN + 1'b1;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]      cfg_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata = '0;   // data_byte
    logic                      s_tlast = 1'b0; // last_byte
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [63:0]               m_tdata;        // match_address
    logic                      m_tuser;        // found

    int fail_count;
    int pending_results;
    int results_checked;
    int hits_seen;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int items_sent = 0;
    int regions_sent = 0;
    int quiet_cycles = 0;

    logic [7:0]  cur_sig [SIG_BYTES];
    logic [15:0] cur_care;
    int          cur_len;

    always #2 aclk = ~aclk;

    wildcard_byte_signature_scan u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    wsbs_scan_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .fail_count     (fail_count),
        .pending_results(pending_results),
        .results_checked(results_checked),
        .hits_seen      (hits_seen)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // all driving tasks start and end on a falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tlast <= is_last;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        items_sent++;
        if (is_last)
            regions_sent++;
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_WIDTH-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic apply_setting(input logic [63:0] base, input logic [63:0] low,
                                 input logic [63:0] high, input logic [15:0] care,
                                 input logic [LEN_BITS-1:0] len);
        wait_idle();
        write_reg(REG_BASE_ADDRESS, base);
        write_reg(REG_PATTERN_LOW, low);
        write_reg(REG_PATTERN_HIGH, high);
        write_reg(REG_CARE_MASK, {$urandom, 16'($urandom), care});
        write_reg(REG_PATTERN_LEN, {$urandom, 27'($urandom), len});
        write_reg(CFG_INDEX_BITS'($urandom_range(REG_UNMAPPED_FIRST, 2**CFG_INDEX_BITS - 1)),
                  {$urandom, $urandom});
        for (int j = 0; j < SIG_BYTES; j++)
            cur_sig[j] = (j < 8) ? low[8*j +: 8] : high[8*(j-8) +: 8];
        cur_care = care;
        cur_len = (len == 0) ? 1 : (len > SIG_BYTES) ? SIG_BYTES : int'(len);
    endtask

    // random bytes, some drawn from the signature, with an optional planted copy that may be spoiled
    task automatic send_region(input int n_bytes, input int plant_at, input bit spoil);
        logic [7:0] region_bytes[$];
        int pick;
        for (int k = 0; k < n_bytes; k++)
            region_bytes.push_back(($urandom_range(3) == 0) ?
                                   cur_sig[$urandom_range(cur_len - 1)] : 8'($urandom));
        if (plant_at >= 0) begin
            for (int j = 0; j < cur_len; j++)
                if (cur_care[j])
                    region_bytes[plant_at + j] = cur_sig[j];
            if (spoil) begin
                pick = $urandom_range(cur_len - 1);
                if (cur_care[pick])
                    region_bytes[plant_at + pick] ^= 8'($urandom_range(1, 255));
            end
        end
        for (int k = 0; k < n_bytes; k++)
            send_byte(region_bytes[k], k == n_bytes - 1);
    endtask

    initial begin
        logic [63:0] base;
        logic [15:0] care;
        logic [LEN_BITS-1:0] len;
        int phase_start;
        int roll;
        int n;
        int plant;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset values: one byte of 0x00, every byte cared
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hFF, 1'b1);

        // three bytes 11 ?? 33 near the top of the address space
        apply_setting(64'hFFFF_FFFF_FFFF_FFFE, 64'hDEAD_BEEF_C033_5A11,
                      64'h0123_4567_89AB_CDEF, 16'hFFFD, LEN_BITS'(3));
        for (int k = REG_UNMAPPED_FIRST; k < 2**CFG_INDEX_BITS; k++)
            write_reg(CFG_INDEX_BITS'(k), '1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h99, 1'b0);
        send_byte(8'h33, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h34, 1'b0);
        send_byte(8'h22, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h88, 1'b1);
        for (int k = 0; k < 3; k++)
            send_byte(8'h00, 1'b0);
        send_byte(8'h11, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h33, 1'b1);

        for (int s = 0; s < SETTINGS_RUN; s++) begin
            case (s)
                0: begin base = '0; len = LEN_BITS'(1); end
                1: begin base = '1; len = LEN_BITS'(16); end
                2: begin base = {$urandom, $urandom}; len = LEN_BITS'(0); end
                3: begin base = 64'hFFFF_FFFF_FFFF_FF00; len = LEN_BITS'(17); end
                4: begin base = {$urandom, $urandom}; len = LEN_BITS'(31); end
                default: begin
                    base = {$urandom, $urandom};
                    len = LEN_BITS'($urandom_range(0, 2**LEN_BITS - 1));
                end
            endcase
            case (s)
                1: care = 16'hFFFF;
                2: care = 16'h0000;
                default: care = 16'($urandom | $urandom);
            endcase
            apply_setting(base, {$urandom, $urandom}, {$urandom, $urandom}, care, len);
            case (s % 4)
                0: begin src_idle_pct = 0; sink_stall_pct = 0; end
                1: begin src_idle_pct = 48; sink_stall_pct = 0; end
                2: begin src_idle_pct = 0; sink_stall_pct = 48; end
                default: begin src_idle_pct = 7; sink_stall_pct = 7; end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                roll = $urandom_range(99);
                if (roll < 5)
                    n = $urandom_range(200, 400);
                else if (roll < 20)
                    n = $urandom_range(1, 3);
                else
                    n = $urandom_range(1, cur_len + 24);
                if (n > PHASE_ITEMS - (items_sent - phase_start))
                    n = PHASE_ITEMS - (items_sent - phase_start);
                plant = -1;
                if (n >= cur_len && $urandom_range(99) < 60)
                    plant = $urandom_range(1) ? n - cur_len : $urandom_range(n - cur_len);
                send_region(n, plant, $urandom_range(99) < 20);
            end
        end

        s_tvalid <= 1'b0;
        while (pending_results != 0)
            @(negedge aclk);
        repeat (8) @(negedge aclk);

        $display("scanned %0d bytes in %0d regions under %0d register settings",
                 items_sent, regions_sent, SETTINGS_RUN + 2);
        $display("checked %0d results, %0d signature hits, all four flow-control mixes",
                 results_checked, hits_seen);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
